@@ rtl/tmse_pkg.sv @@
// tmse_pkg: field widths, symbol and code constants, rule and chain types
// for the turing machine step engine. depends on nothing.
package tmse_pkg;

   // field widths of the request and response channels
   localparam int KIND_W       = 3;
   localparam int RULE_STATE_W = 6;
   localparam int SLOT_W       = 3;
   localparam int SYM_W        = 8;
   localparam int MOVE_W       = 2;
   localparam int CODE_W       = 7;
   localparam int CELL_ADDR_W  = 10;
   localparam int STATUS_W     = 3;
   localparam int COUNT_W      = 32;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_RULE    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CELL    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_RESTART = 3'd2;
   localparam logic [KIND_W-1:0] KIND_STEP    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_READ    = 3'd4;

   // tape symbols
   localparam logic [SYM_W-1:0] SYM_WILD  = 8'd42;
   localparam logic [SYM_W-1:0] SYM_BLANK = 8'd95;
   localparam logic [SYM_W-1:0] SYM_SPACE = 8'd32;

   // halt codes of the rule target code; accept and reject also enter the state register
   localparam logic [CODE_W-1:0] CODE_ACCEPT = 7'd64;
   localparam logic [CODE_W-1:0] CODE_REJECT = 7'd65;
   localparam logic [CODE_W-1:0] CODE_ERROR  = 7'd66;

   // head moves
   localparam logic [MOVE_W-1:0] MOVE_LEFT  = 2'd0;
   localparam logic [MOVE_W-1:0] MOVE_RIGHT = 2'd1;

   // run status codes
   localparam logic [STATUS_W-1:0] STAT_RUN     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_ACCEPT  = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REJECT  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NORULE  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_OFFTAPE = 3'd4;

   // one transition rule slot
   typedef struct packed {
      logic              valid;
      logic [SYM_W-1:0]  match_symbol;
      logic [SYM_W-1:0]  put_symbol;
      logic [MOVE_W-1:0] head_move;
      logic [CODE_W-1:0] target_code;
   } rule_type;

   // search result handed from one rule cell to the next
   typedef struct packed {
      logic     exact_hit;
      rule_type exact_rule;
      logic     wild_hit;
      rule_type wild_rule;
   } rule_chain_type;

   // sequencer states
   typedef enum logic [1:0] {
      CTRL_CLEAR,
      CTRL_IDLE,
      CTRL_EXEC
   } ctrl_state_type;

endpackage

@@ rtl/tmse_req_if.sv @@
// tmse_req_if: request channel of the step engine, valid/ready plus payload.
// depends on tmse_pkg for field widths.
interface tmse_req_if import tmse_pkg::*; ();

   logic                    valid;
   logic                    ready;
   logic [KIND_W-1:0]       kind;
   logic [RULE_STATE_W-1:0] rule_state;
   logic [SLOT_W-1:0]       rule_slot;
   logic                    rule_valid;
   logic [SYM_W-1:0]        match_symbol;
   logic [SYM_W-1:0]        put_symbol;
   logic [MOVE_W-1:0]       head_move;
   logic [CODE_W-1:0]       target_code;
   logic [CELL_ADDR_W-1:0]  cell_addr;
   logic [SYM_W-1:0]        cell_value;

   modport source (
      output valid, kind, rule_state, rule_slot, rule_valid, match_symbol,
             put_symbol, head_move, target_code, cell_addr, cell_value,
      input  ready
   );

   modport sink (
      input  valid, kind, rule_state, rule_slot, rule_valid, match_symbol,
             put_symbol, head_move, target_code, cell_addr, cell_value,
      output ready
   );

endinterface

@@ rtl/tmse_rsp_if.sv @@
// tmse_rsp_if: response channel of the step engine, valid/ready plus payload.
// depends on tmse_pkg for field widths.
interface tmse_rsp_if import tmse_pkg::*; ();

   logic                   valid;
   logic                   ready;
   logic [STATUS_W-1:0]    status;
   logic [CODE_W-1:0]      state_code;
   logic [CELL_ADDR_W-1:0] head_pos;
   logic [SYM_W-1:0]       seen_symbol;
   logic [COUNT_W-1:0]     step_count;

   modport source (
      output valid, status, state_code, head_pos, seen_symbol, step_count,
      input  ready
   );

   modport sink (
      input  valid, status, state_code, head_pos, seen_symbol, step_count,
      output ready
   );

endinterface

@@ rtl/tmse_ram.sv @@
// tmse_ram: generic simple dual-port ram, one write and one registered read.
// depends on nothing.
module tmse_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tmse_rule_cell.sv @@
// tmse_rule_cell: one rule slot column; holds that slot for every state and
// merges its match into the search chain. depends on tmse_pkg, tmse_ram.
module tmse_rule_cell import tmse_pkg::*; #(
   parameter int  NUM_STATES = 64,
   localparam int STATE_W    = $clog2(NUM_STATES)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [STATE_W-1:0] wr_row,
   input  rule_type           wr_rule,
   input  logic               rd_en,
   input  logic [STATE_W-1:0] rd_row,
   input  logic               row_ok,
   input  logic [SYM_W-1:0]   symbol,
   input  rule_chain_type     chain_in,
   output rule_chain_type     chain_out
);

   logic [$bits(rule_type)-1:0] rd_word;
   rule_type                    slot_rule;
   logic                        slot_valid;

   // slot storage, one word per state
   tmse_ram #(
      .WIDTH ($bits(rule_type)),
      .DEPTH (NUM_STATES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_row),
      .wr_data (wr_rule),
      .rd_en   (rd_en),
      .rd_addr (rd_row),
      .rd_data (rd_word)
   );

   assign slot_rule  = rule_type'(rd_word);
   assign slot_valid = row_ok && slot_rule.valid;

   // first exact match wins, last wildcard wins
   always_comb begin
      chain_out = chain_in;
      if (!chain_in.exact_hit && slot_valid && slot_rule.match_symbol == symbol) begin
         chain_out.exact_hit  = 1'b1;
         chain_out.exact_rule = slot_rule;
      end
      if (slot_valid && slot_rule.match_symbol == SYM_WILD) begin
         chain_out.wild_hit  = 1'b1;
         chain_out.wild_rule = slot_rule;
      end
   end

endmodule

@@ rtl/turing_machine_step_engine_core.sv @@
// turing_machine_step_engine_core: top level of the single-tape turing machine.
// depends on tmse_pkg, tmse_req_if, tmse_rsp_if, tmse_ram, tmse_rule_cell.
//
// usage
//   req_if carries one request per valid/ready handshake: rule write, tape cell
//   write, restart, one machine step or tape cell read. rsp_if returns exactly
//   one response per request, in order. csr_wr_en/csr_wr_data set head_start,
//   the head position taken on restart; write it only while the block is idle.
//   a request is taken in idle: the accept cycle reads the tape cell under the head
//   (or the requested cell for a read) and the current state's rule row from all
//   slot cells in parallel; the execute state then runs the slot chain, writes the
//   tape back and loads the response register. req_if.ready rises again the cycle
//   after that, so no new request is taken until the current one has executed.
//   the response register lets the next request be accepted while a response
//   waits; if rsp_if.ready stays low the second request holds in its execute
//   cycle until the response register frees up.
//   after reset the block sweeps every tape cell to blank space, one cell a cycle,
//   with req_if.ready low; csr writes are taken as usual.
//   rule rows are marked empty at once by per-state valid bits.
module turing_machine_step_engine_core import tmse_pkg::*; #(
   parameter int NUM_STATES      = 64,
   parameter int RULES_PER_STATE = 8,
   parameter int TAPE_CELLS      = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   tmse_req_if.sink               req_if,
   tmse_rsp_if.source             rsp_if,
   input  logic                   csr_wr_en,
   input  logic [CELL_ADDR_W-1:0] csr_wr_data
);

   localparam int STATE_W = $clog2(NUM_STATES);
   localparam int TAPE_AW = $clog2(TAPE_CELLS);
   localparam int HEAD_W  = (TAPE_AW > CELL_ADDR_W) ? TAPE_AW : CELL_ADDR_W;
   localparam logic [TAPE_AW-1:0] TAPE_LAST = TAPE_AW'(TAPE_CELLS - 1);

   // control
   ctrl_state_type ctrl_ff, ctrl_in;
   logic [TAPE_AW-1:0] clr_ff, clr_in;
   logic ready;
   logic accept;
   logic out_free;
   logic exec_done;
   logic clearing;

   // machine state
   logic [CELL_ADDR_W-1:0] head_start_ff;
   logic [NUM_STATES-1:0]  row_valid_ff;
   logic                   row_ok_ff;
   logic [KIND_W-1:0]      kind_ff;
   logic                   addr_ok_ff;
   logic [CODE_W-1:0]      cur_state_ff, cur_state_in;
   logic [HEAD_W-1:0]      head_ff, head_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [STATUS_W-1:0]    status_ff, status_in;
   logic [SYM_W-1:0]       seen_in;

   // response register
   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [CODE_W-1:0]      rsp_state_ff;
   logic [CELL_ADDR_W-1:0] rsp_head_ff;
   logic [SYM_W-1:0]       rsp_seen_ff;
   logic [COUNT_W-1:0]     rsp_count_ff;

   // request side decode
   logic                   cell_addr_ok;
   logic                   rule_wr;
   logic [STATE_W-1:0]     wr_row;
   logic                   row_fresh;
   rule_type               new_rule;
   logic [STATE_W-1:0]     rd_row;

   // tape port
   logic                   tape_we;
   logic [TAPE_AW-1:0]     tape_waddr;
   logic [SYM_W-1:0]       tape_wdata;
   logic [TAPE_AW-1:0]     tape_raddr;
   logic [SYM_W-1:0]       tape_rdata;

   // step datapath
   logic                   head_on_tape;
   logic [SYM_W-1:0]       symbol;
   rule_chain_type         chain [RULES_PER_STATE+1];
   rule_type               sel_rule;
   logic                   have_rule;
   logic                   step_wr;
   logic [SYM_W-1:0]       step_wdata;
   logic                   off_tape;

   // sequencer: clear sweep, idle, execute
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= CTRL_CLEAR;
         clr_ff  <= '0;
      end else begin
         ctrl_ff <= ctrl_in;
         clr_ff  <= clr_in;
      end
   end

   always_comb begin
      ctrl_in   = ctrl_ff;
      clr_in    = clr_ff;
      ready     = 1'b0;
      exec_done = 1'b0;
      clearing  = 1'b0;
      unique case (ctrl_ff)
         CTRL_CLEAR: begin
            clearing = 1'b1;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == TAPE_LAST) begin
               ctrl_in = CTRL_IDLE;
            end
         end
         CTRL_IDLE: begin
            ready = 1'b1;
            if (req_if.valid) begin
               ctrl_in = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            if (out_free) begin
               exec_done = 1'b1;
               ctrl_in   = CTRL_IDLE;
            end
         end
         default: begin
            ctrl_in = CTRL_IDLE;
         end
      endcase
   end

   assign req_if.ready = ready;
   assign accept       = req_if.valid && ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // request decode
   assign cell_addr_ok = 32'(req_if.cell_addr) < TAPE_CELLS;
   assign rule_wr      = accept && req_if.kind == KIND_RULE
                         && 32'(req_if.rule_state) < NUM_STATES
                         && 32'(req_if.rule_slot) < RULES_PER_STATE;
   assign wr_row       = STATE_W'(req_if.rule_state);
   assign row_fresh    = !row_valid_ff[wr_row];
   assign rd_row       = STATE_W'(cur_state_ff);

   always_comb begin
      new_rule.valid        = req_if.rule_valid;
      new_rule.match_symbol = req_if.match_symbol;
      new_rule.put_symbol   = req_if.put_symbol;
      new_rule.head_move    = req_if.head_move;
      new_rule.target_code  = req_if.target_code;
   end

   // row of slot cells; a write to an empty row clears its other slots too
   assign chain[0] = '0;

   for (genvar g = 0; g < RULES_PER_STATE; g++) begin : g_slot
      logic     slot_we;
      rule_type slot_wdata;

      assign slot_we    = rule_wr && (row_fresh || 32'(req_if.rule_slot) == g);
      assign slot_wdata = (32'(req_if.rule_slot) == g) ? new_rule : '0;

      tmse_rule_cell #(
         .NUM_STATES (NUM_STATES)
      ) u_cell (
         .clock     (clock),
         .wr_en     (slot_we),
         .wr_row    (wr_row),
         .wr_rule   (slot_wdata),
         .rd_en     (accept),
         .rd_row    (rd_row),
         .row_ok    (row_ok_ff),
         .symbol    (symbol),
         .chain_in  (chain[g]),
         .chain_out (chain[g+1])
      );
   end

   // tape port arbitration
   assign tape_raddr = (req_if.kind == KIND_READ) ? TAPE_AW'(req_if.cell_addr)
                                                  : TAPE_AW'(head_ff);

   always_comb begin
      tape_we    = 1'b0;
      tape_waddr = clr_ff;
      tape_wdata = SYM_SPACE;
      priority if (clearing) begin
         tape_we = 1'b1;
      end else if (accept && req_if.kind == KIND_CELL && cell_addr_ok) begin
         tape_we    = 1'b1;
         tape_waddr = TAPE_AW'(req_if.cell_addr);
         tape_wdata = req_if.cell_value;
      end else if (exec_done && step_wr) begin
         tape_we    = 1'b1;
         tape_waddr = TAPE_AW'(head_ff);
         tape_wdata = step_wdata;
      end else begin
         tape_we = 1'b0;
      end
   end

   tmse_ram #(
      .WIDTH (SYM_W),
      .DEPTH (TAPE_CELLS)
   ) u_tape_ram (
      .clock   (clock),
      .wr_en   (tape_we),
      .wr_addr (tape_waddr),
      .wr_data (tape_wdata),
      .rd_en   (accept),
      .rd_addr (tape_raddr),
      .rd_data (tape_rdata)
   );

   // symbol under the head; space, or a head off the tape, reads as blank
   assign head_on_tape = 32'(head_ff) < TAPE_CELLS;
   assign symbol       = (!head_on_tape || tape_rdata == SYM_SPACE) ? SYM_BLANK : tape_rdata;

   assign have_rule = chain[RULES_PER_STATE].exact_hit || chain[RULES_PER_STATE].wild_hit;
   assign sel_rule  = chain[RULES_PER_STATE].exact_hit ? chain[RULES_PER_STATE].exact_rule
                                                       : chain[RULES_PER_STATE].wild_rule;

   // next machine state for the request in execute
   always_comb begin
      cur_state_in = cur_state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      seen_in      = '0;
      step_wr      = 1'b0;
      step_wdata   = (sel_rule.put_symbol == SYM_BLANK) ? SYM_SPACE : sel_rule.put_symbol;
      off_tape     = 1'b0;
      unique case (kind_ff)
         KIND_RESTART: begin
            cur_state_in = '0;
            head_in      = HEAD_W'(head_start_ff);
            count_in     = '0;
            status_in    = (32'(head_start_ff) < TAPE_CELLS) ? STAT_RUN : STAT_OFFTAPE;
         end
         KIND_STEP: begin
            seen_in = symbol;
            if (status_ff == STAT_RUN && 32'(cur_state_ff) < NUM_STATES && head_on_tape) begin
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
               if (!have_rule || sel_rule.target_code == CODE_ERROR) begin
                  status_in = STAT_NORULE;
               end else begin
                  step_wr = sel_rule.put_symbol != SYM_WILD;
                  // head move, stopped at the tape edges
                  if (sel_rule.head_move == MOVE_LEFT) begin
                     if (head_ff == '0) begin
                        off_tape = 1'b1;
                     end else begin
                        head_in = head_ff - 1'b1;
                     end
                  end else if (sel_rule.head_move == MOVE_RIGHT) begin
                     if (32'(head_ff) + 32'd1 >= TAPE_CELLS) begin
                        off_tape = 1'b1;
                     end else begin
                        head_in = head_ff + 1'b1;
                     end
                  end
                  // state transition
                  if (off_tape) begin
                     status_in = STAT_OFFTAPE;
                  end else if (sel_rule.target_code == CODE_ACCEPT) begin
                     cur_state_in = sel_rule.target_code;
                     status_in    = STAT_ACCEPT;
                  end else if (sel_rule.target_code == CODE_REJECT) begin
                     cur_state_in = sel_rule.target_code;
                     status_in    = STAT_REJECT;
                  end else if (sel_rule.target_code < CODE_ACCEPT
                               && 32'(sel_rule.target_code) < NUM_STATES) begin
                     cur_state_in = sel_rule.target_code;
                  end else begin
                     status_in = STAT_NORULE;
                  end
               end
            end
         end
         KIND_READ: begin
            seen_in = addr_ok_ff ? tape_rdata : '0;
         end
         default: begin
            seen_in = '0;
         end
      endcase
   end

   // control and machine registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_start_ff <= '0;
         row_valid_ff  <= '0;
         cur_state_ff  <= '0;
         head_ff       <= '0;
         count_ff      <= '0;
         status_ff     <= STAT_RUN;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            head_start_ff <= csr_wr_data;
         end
         if (rule_wr) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
         if (exec_done) begin
            cur_state_ff <= cur_state_in;
            head_ff      <= head_in;
            count_ff     <= count_in;
            status_ff    <= status_in;
         end
         if (exec_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request latch and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_if.kind;
         addr_ok_ff <= cell_addr_ok;
         row_ok_ff  <= row_valid_ff[rd_row];
      end
      if (exec_done) begin
         rsp_status_ff <= status_in;
         rsp_state_ff  <= cur_state_in;
         rsp_head_ff   <= head_in[CELL_ADDR_W-1:0];
         rsp_seen_ff   <= seen_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.state_code  = rsp_state_ff;
   assign rsp_if.head_pos    = rsp_head_ff;
   assign rsp_if.seen_symbol = rsp_seen_ff;
   assign rsp_if.step_count  = rsp_count_ff;

endmodule
